// ===== hdl/nccc_pkg.sv =====
// ----------------------------------------------------------------------------
// nccc_pkg
// Shared sizes, types and helpers of the nearest-centroid confusion counter.
// ----------------------------------------------------------------------------
package nccc_pkg;

    localparam int NUM_CENTRES    = 6;
    localparam int SAMPLE_BITS    = 12;
    localparam int COUNT_BITS     = 16;
    localparam int IDX_BITS       = 3;
    localparam int SQ_BITS        = 2 * SAMPLE_BITS;
    localparam int DIST_BITS      = SQ_BITS + 2;
    localparam int CELL_COUNT     = NUM_CENTRES * NUM_CENTRES;
    localparam int CELL_ADDR_BITS = $clog2(CELL_COUNT);
    localparam int CENTRE_ADDR_BITS = $clog2(NUM_CENTRES);

    localparam logic [CENTRE_ADDR_BITS-1:0] LAST_CENTRE =
        CENTRE_ADDR_BITS'(NUM_CENTRES - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    localparam logic [1:0] OP_LOAD     = 2'd0;
    localparam logic [1:0] OP_CLASSIFY = 2'd1;
    localparam logic [1:0] OP_READ     = 2'd2;
    localparam logic [1:0] OP_CLEAR    = 2'd3;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] z;
        logic [SAMPLE_BITS-1:0] y;
        logic [SAMPLE_BITS-1:0] x;
    } t_point;

    typedef struct packed {
        logic                   valid;
        logic [CENTRE_ADDR_BITS-1:0] index;
    } t_dist_ctl;

    typedef struct packed {
        logic                      clr;
        logic                      rd;
        logic                      wr;
        logic [CELL_ADDR_BITS-1:0] rd_addr;
        logic [CELL_ADDR_BITS-1:0] wr_addr;
    } t_cnt_cmd;

    function automatic logic [CELL_ADDR_BITS-1:0] cell_addr(
        input logic [IDX_BITS-1:0] row,
        input logic [IDX_BITS-1:0] col
    );
        logic [CELL_ADDR_BITS-1:0] r;
        r = CELL_ADDR_BITS'(row);
        return CELL_ADDR_BITS'(r * CELL_ADDR_BITS'(NUM_CENTRES)) + CELL_ADDR_BITS'(col);
    endfunction

endpackage

// ===== hdl/nccc_centre_mem.sv =====
// ----------------------------------------------------------------------------
// nccc_centre_mem
// Centre point store: one write port, one registered read port, per-entry
// valid bits so that unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module nccc_centre_mem
    import nccc_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_wr_en,
    input  logic [CENTRE_ADDR_BITS-1:0] i_wr_addr,
    input  t_point                      i_wr_data,
    input  logic                        i_rd_en,
    input  logic [CENTRE_ADDR_BITS-1:0] i_rd_addr,
    output t_point                      o_rd_data
);

    t_point                 r_mem [NUM_CENTRES];
    logic [NUM_CENTRES-1:0] r_vld;
    t_point                 r_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_vld[i_rd_addr] ? r_mem[i_rd_addr] : '0;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/nccc_count_mem.sv =====
// ----------------------------------------------------------------------------
// nccc_count_mem
// Confusion count store: one write port, one registered read port. Valid
// bits give zero for cells not written since reset or the last clear.
// ----------------------------------------------------------------------------
module nccc_count_mem
    import nccc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cnt_cmd              i_cmd,
    input  logic [COUNT_BITS-1:0] i_wr_data,
    output logic [COUNT_BITS-1:0] o_rd_data
);

    logic [COUNT_BITS-1:0] r_mem [CELL_COUNT];
    logic [CELL_COUNT-1:0] r_vld;
    logic [COUNT_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_cmd.clr) begin
            r_vld <= '0;
        end else if (i_cmd.wr) begin
            r_vld[i_cmd.wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_mem[i_cmd.wr_addr] <= i_wr_data;
        end
        if (i_cmd.rd) begin
            r_rd_data <= r_vld[i_cmd.rd_addr] ? r_mem[i_cmd.rd_addr] : '0;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/nccc_dist_unit.sv =====
// ----------------------------------------------------------------------------
// nccc_dist_unit
// Two-stage squared distance pipe with a running minimum. Squares are
// registered, then summed and compared; the lowest index wins a tie.
// ----------------------------------------------------------------------------
module nccc_dist_unit
    import nccc_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_point                      i_sample,
    input  t_point                      i_centre,
    input  t_dist_ctl                   i_ctl,
    output logic [DIST_BITS-1:0]        o_best,
    output logic [CENTRE_ADDR_BITS-1:0] o_win,
    output logic                        o_done
);

    logic [SAMPLE_BITS-1:0]      dx, dy, dz;
    logic [SQ_BITS-1:0]          r_sq_x, r_sq_y, r_sq_z;
    t_dist_ctl                   r_s1;
    logic [DIST_BITS-1:0]        sum;
    logic [DIST_BITS-1:0]        r_best;
    logic [CENTRE_ADDR_BITS-1:0] r_win;
    logic                        r_done;

    always_comb begin
        dx = (i_sample.x >= i_centre.x) ? i_sample.x - i_centre.x : i_centre.x - i_sample.x;
        dy = (i_sample.y >= i_centre.y) ? i_sample.y - i_centre.y : i_centre.y - i_sample.y;
        dz = (i_sample.z >= i_centre.z) ? i_sample.z - i_centre.z : i_centre.z - i_sample.z;
        sum = DIST_BITS'(r_sq_x) + DIST_BITS'(r_sq_y) + DIST_BITS'(r_sq_z);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_s1.valid <= i_ctl.valid;
            r_done     <= r_s1.valid && (r_s1.index == LAST_CENTRE);
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1.index <= i_ctl.index;
        r_sq_x     <= SQ_BITS'(dx) * SQ_BITS'(dx);
        r_sq_y     <= SQ_BITS'(dy) * SQ_BITS'(dy);
        r_sq_z     <= SQ_BITS'(dz) * SQ_BITS'(dz);
        if (r_s1.valid && ((r_s1.index == '0) || (sum < r_best))) begin
            r_best <= sum;
            r_win  <= r_s1.index;
        end
    end

    assign o_best = r_best;
    assign o_win  = r_win;
    assign o_done = r_done;

endmodule

// ===== hdl/nearest_centroid_confusion_counter_top.sv =====
// ----------------------------------------------------------------------------
// nearest_centroid_confusion_counter_top
// Nearest-centroid classifier over x, y, z with a confusion count matrix.
// ----------------------------------------------------------------------------
// One transfer in gives one transfer out. A load or a clear goes from the
// input transfer straight into the output register; a read passes through the
// registered read of the count memory first. A classify walks the centre
// memory at one entry per cycle, passes its registered read port and the
// two-stage distance pipe, does the read-modify-write of the count memory and
// goes into the output register. A new input is taken only from the cycle in
// which the previous result appears, while that result may still be waiting;
// a result still held in the output register stalls the next item in its last
// step. Both stores are cleared at reset through valid bits, so the block is
// ready in the first cycle.
module nearest_centroid_confusion_counter_top
    import nccc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // row_index[2:0], column_index[5:3], coord_x[17:6], coord_y[29:18],
    // coord_z[41:30], count_enable[42], zero[47:43]
    input  logic [47:0] i_s_axis_tdata,
    // opcode[1:0]
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // winner_index[2:0], min_distance[28:3], count_value[44:29], zero[47:45]
    output logic [47:0] o_m_axis_tdata
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_UPD   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    typedef struct packed {
        logic                   count_enable;
        logic [SAMPLE_BITS-1:0] z;
        logic [SAMPLE_BITS-1:0] y;
        logic [SAMPLE_BITS-1:0] x;
        logic [IDX_BITS-1:0]    col;
        logic [IDX_BITS-1:0]    row;
    } t_in_fields;

    localparam int IN_FIELD_BITS = $bits(t_in_fields);

    logic [2:0]                  r_state, n_state;
    t_in_fields                  in_f;
    logic                        in_acc;
    logic                        in_row_ok, in_col_ok;
    logic [1:0]                  in_op;

    t_point                      r_sample;
    logic                        r_row_ok;
    logic                        r_rd_ok;
    logic                        r_en;
    logic [IDX_BITS-1:0]         r_row;
    logic [CENTRE_ADDR_BITS-1:0] r_idx;
    logic [CELL_ADDR_BITS-1:0]   r_caddr;
    t_dist_ctl                   r_dctl;

    logic [IDX_BITS-1:0]         r_res_win;
    logic [DIST_BITS-1:0]        r_res_dist;
    logic [COUNT_BITS-1:0]       r_res_cnt;
    logic                        r_m_valid;
    logic [47:0]                 r_m_data;

    t_point                      ctr_rd_data;
    logic                        ctr_wr;
    logic                        ctr_rd;
    t_cnt_cmd                    cnt_cmd;
    logic [COUNT_BITS-1:0]       cnt_rd_data;
    logic [COUNT_BITS-1:0]       cnt_new;
    logic [DIST_BITS-1:0]        d_best;
    logic [CENTRE_ADDR_BITS-1:0] d_win;
    logic                        d_done;
    logic                        out_free;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_acc    = i_s_axis_tvalid && (r_state == S_IDLE);
    assign in_f      = t_in_fields'(i_s_axis_tdata[IN_FIELD_BITS-1:0]);
    assign in_op     = i_s_axis_tuser;
    assign in_row_ok = (int'(in_f.row) < NUM_CENTRES);
    assign in_col_ok = (int'(in_f.col) < NUM_CENTRES);
    assign out_free  = !r_m_valid || i_m_axis_tready;
    assign cnt_new   = (r_en && (cnt_rd_data != COUNT_MAX)) ? cnt_rd_data + 1'b1
                                                            : cnt_rd_data;

    always_comb begin
        ctr_wr          = in_acc && (in_op == OP_LOAD) && in_row_ok;
        ctr_rd          = (r_state == S_SCAN);
        cnt_cmd.clr     = in_acc && (in_op == OP_CLEAR);
        cnt_cmd.rd      = 1'b0;
        cnt_cmd.rd_addr = cell_addr(in_f.row, in_f.col);
        cnt_cmd.wr      = (r_state == S_UPD) && r_row_ok && r_en;
        cnt_cmd.wr_addr = r_caddr;
        if (in_acc && (in_op == OP_READ)) begin
            cnt_cmd.rd = in_row_ok && in_col_ok;
        end else if (r_state == S_DRAIN) begin
            cnt_cmd.rd      = d_done && r_row_ok;
            cnt_cmd.rd_addr = cell_addr(r_row, IDX_BITS'(d_win));
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (in_op)
                        OP_CLASSIFY: n_state = S_SCAN;
                        OP_READ:     n_state = S_READ;
                        default:     n_state = S_OUT;
                    endcase
                end
            end
            S_READ:  n_state = S_OUT;
            S_SCAN:  n_state = (r_idx == LAST_CENTRE) ? S_DRAIN : S_SCAN;
            S_DRAIN: n_state = d_done ? S_UPD : S_DRAIN;
            S_UPD:   n_state = S_OUT;
            S_OUT:   n_state = out_free ? S_IDLE : S_OUT;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_dctl.valid <= 1'b0;
            r_m_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_dctl.valid <= ctr_rd;
            if ((r_state == S_OUT) && out_free) begin
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dctl.index <= r_idx;
        if (in_acc) begin
            r_sample   <= t_point'{z: in_f.z, y: in_f.y, x: in_f.x};
            r_row      <= in_f.row;
            r_row_ok   <= in_row_ok;
            r_rd_ok    <= in_row_ok && in_col_ok;
            r_en       <= in_f.count_enable;
            r_idx      <= '0;
            r_res_win  <= '0;
            r_res_dist <= '0;
            r_res_cnt  <= '0;
        end
        if (r_state == S_SCAN) begin
            r_idx <= r_idx + 1'b1;
        end
        if (r_state == S_READ) begin
            r_res_cnt <= r_rd_ok ? cnt_rd_data : '0;
        end
        if ((r_state == S_DRAIN) && d_done) begin
            r_res_win  <= IDX_BITS'(d_win);
            r_res_dist <= d_best;
            r_caddr    <= cell_addr(r_row, IDX_BITS'(d_win));
        end
        if (r_state == S_UPD) begin
            r_res_cnt <= r_row_ok ? cnt_new : '0;
        end
        if ((r_state == S_OUT) && out_free) begin
            r_m_data <= 48'({r_res_cnt, r_res_dist, r_res_win});
        end
    end

    nccc_centre_mem u_centre_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (ctr_wr),
        .i_wr_addr (CENTRE_ADDR_BITS'(in_f.row)),
        .i_wr_data (t_point'{z: in_f.z, y: in_f.y, x: in_f.x}),
        .i_rd_en   (ctr_rd),
        .i_rd_addr (r_idx),
        .o_rd_data (ctr_rd_data)
    );

    nccc_dist_unit u_dist_unit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (r_sample),
        .i_centre (ctr_rd_data),
        .i_ctl    (r_dctl),
        .o_best   (d_best),
        .o_win    (d_win),
        .o_done   (d_done)
    );

    nccc_count_mem u_count_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cnt_cmd),
        .i_wr_data (cnt_new),
        .o_rd_data (cnt_rd_data)
    );

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

endmodule

// ===== tb/nearest_centroid_confusion_counter_top_tb.sv =====
// ----------------------------------------------------------------------------
// nearest_centroid_confusion_counter_top_tb
// Self-checking bench for the nearest-centroid confusion counter. A predictor
// in the scoreboard tracks the centre points and counts, and works out the
// answer to every accepted request. The answers are matched in order against
// the output stream. Stimulus is a directed opening (extremes, ties, ranges,
// clear) and a run of repeated classifies into one count. A random
// mix of loads, classifies, reads and clears follows. The sender works in
// bursts and the receiver stalls on patterns of its own.
// ----------------------------------------------------------------------------
module nearest_centroid_confusion_counter_top_tb;
    import nccc_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int RANDOM_ITEMS = 1400;
    localparam int REPEAT_RUN   = 40;
    localparam int PRINT_CAP    = 40;
    localparam int TAIL_CYCLES  = 20;

    typedef struct packed {
        logic                count_enable;
        t_point              pt;
        logic [IDX_BITS-1:0] col;
        logic [IDX_BITS-1:0] row;
    } t_request;

    typedef struct packed {
        logic [2:0]            pad;
        logic [COUNT_BITS-1:0] count;
        logic [DIST_BITS-1:0]  distance;
        logic [IDX_BITS-1:0]   winner;
    } t_answer;

    typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SLOW, RX_BEAT} t_rx_mode;

    class confusion_scoreboard;
        t_point                centres [NUM_CENTRES];
        logic [COUNT_BITS-1:0] counts [CELL_COUNT];
        t_answer               pending_answers [$];
        int                    fail_count;

        function new();
            foreach (centres[i]) centres[i] = '0;
            foreach (counts[i]) counts[i] = '0;
            fail_count = 0;
        endfunction

        function logic [DIST_BITS-1:0] squared_gap(t_point a, t_point b);
            logic [DIST_BITS-1:0] dx, dy, dz;
            dx = (a.x >= b.x) ? DIST_BITS'(a.x - b.x) : DIST_BITS'(b.x - a.x);
            dy = (a.y >= b.y) ? DIST_BITS'(a.y - b.y) : DIST_BITS'(b.y - a.y);
            dz = (a.z >= b.z) ? DIST_BITS'(a.z - b.z) : DIST_BITS'(b.z - a.z);
            return dx * dx + dy * dy + dz * dz;
        endfunction

        function void note_request(logic [1:0] op, t_request rq);
            t_answer              ans;
            logic [DIST_BITS-1:0] d;
            int                   win;
            int                   cell_idx;
            ans = '0;
            case (op)
                OP_LOAD: begin
                    if (rq.row < NUM_CENTRES) centres[rq.row] = rq.pt;
                end
                OP_CLASSIFY: begin
                    ans.distance = squared_gap(rq.pt, centres[0]);
                    win = 0;
                    for (int j = 1; j < NUM_CENTRES; j++) begin
                        d = squared_gap(rq.pt, centres[j]);
                        if (d < ans.distance) begin
                            ans.distance = d;
                            win = j;
                        end
                    end
                    ans.winner = IDX_BITS'(win);
                    if (rq.row < NUM_CENTRES) begin
                        cell_idx = rq.row * NUM_CENTRES + win;
                        if (rq.count_enable && counts[cell_idx] != COUNT_MAX)
                            counts[cell_idx] = counts[cell_idx] + 1'b1;
                        ans.count = counts[cell_idx];
                    end
                end
                OP_READ: begin
                    if (rq.row < NUM_CENTRES && rq.col < NUM_CENTRES)
                        ans.count = counts[rq.row * NUM_CENTRES + rq.col];
                end
                OP_CLEAR: begin
                    foreach (counts[i]) counts[i] = '0;
                end
            endcase
            pending_answers.push_back(ans);
        endfunction

        task report_mismatch(string msg);
            if (fail_count < PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
            fail_count++;
        endtask

        task check_answer(logic [47:0] data);
            t_answer got;
            t_answer want;
            got = data;
            if (pending_answers.size() == 0) begin
                report_mismatch($sformatf("result %h with nothing outstanding", data));
            end else begin
                want = pending_answers.pop_front();
                if (got.winner != want.winner)
                    report_mismatch($sformatf("winner_index %0d, want %0d",
                                              got.winner, want.winner));
                if (got.distance != want.distance)
                    report_mismatch($sformatf("min_distance %0d, want %0d",
                                              got.distance, want.distance));
                if (got.count != want.count)
                    report_mismatch($sformatf("count_value %0d, want %0d",
                                              got.count, want.count));
                if (got.pad != '0)
                    report_mismatch($sformatf("padding bits %b not zero", got.pad));
            end
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [47:0] i_s_axis_tdata  = '0;
    logic [1:0]  i_s_axis_tuser  = OP_LOAD;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [47:0] o_m_axis_tdata;

    confusion_scoreboard sb = new();

    t_rx_mode rx_mode      = RX_FREE;
    int       rx_left      = 0;
    int       rx_tick      = 0;
    int       quiet_cycles = 0;
    bit       rx_eager     = 1'b0;

    nearest_centroid_confusion_counter_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver: check each transfer, then pick the next ready level
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_answer(o_m_axis_tdata);
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(32, 300);
        end
        rx_left--;
        rx_tick++;
        if (rx_eager) begin
            i_m_axis_tready <= 1'b1;
        end else begin
            case (rx_mode)
                RX_FREE: i_m_axis_tready <= 1'b1;
                RX_COIN: i_m_axis_tready <= 1'($urandom_range(0, 1));
                RX_SLOW: i_m_axis_tready <= ($urandom_range(0, 3) == 0);
                RX_BEAT: i_m_axis_tready <= ((rx_tick % 5) < 2);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("nearest_centroid_confusion_counter_top verification failed");
            $finish;
        end
    end

    task automatic send_request(logic [1:0] op, t_request rq);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= op;
        i_s_axis_tdata  <= 48'(rq);
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_request(op, rq);
    endtask

    task automatic put(logic [1:0] op, int row, int col, int x, int y, int z, bit en);
        t_request rq;
        rq.row          = IDX_BITS'(row);
        rq.col          = IDX_BITS'(col);
        rq.pt.x         = SAMPLE_BITS'(x);
        rq.pt.y         = SAMPLE_BITS'(y);
        rq.pt.z         = SAMPLE_BITS'(z);
        rq.count_enable = en;
        send_request(op, rq);
    endtask

    task automatic pause(int n);
        if (n > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending_answers.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [SAMPLE_BITS-1:0] edge_coord();
        return $urandom_range(0, 1) ? '1 : '0;
    endfunction

    function automatic logic [IDX_BITS-1:0] biased_index();
        return ($urandom_range(0, 3) == 0) ? IDX_BITS'($urandom_range(0, 7))
                                            : IDX_BITS'($urandom_range(0, NUM_CENTRES - 1));
    endfunction

    task automatic make_random(output logic [1:0] op, output t_request rq);
        int     pick;
        t_point a;
        t_point b;
        a = sb.centres[$urandom_range(0, NUM_CENTRES - 1)];
        b = sb.centres[$urandom_range(0, NUM_CENTRES - 1)];
        rq.row          = IDX_BITS'($urandom_range(0, 7));
        rq.col          = IDX_BITS'($urandom_range(0, 7));
        rq.count_enable = 1'($urandom_range(0, 1));
        rq.pt.x         = SAMPLE_BITS'($urandom_range(0, 4095));
        rq.pt.y         = SAMPLE_BITS'($urandom_range(0, 4095));
        rq.pt.z         = SAMPLE_BITS'($urandom_range(0, 4095));
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            op = OP_LOAD;
            case ($urandom_range(0, 5))
                0: rq.pt = a;                     // duplicate centre, makes ties likely
                1: begin
                    rq.pt.x = edge_coord();
                    rq.pt.y = edge_coord();
                    rq.pt.z = edge_coord();
                end
                default: ;
            endcase
        end else if (pick < 70) begin
            op = OP_CLASSIFY;
            rq.row = biased_index();
            rq.count_enable = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 5))
                2: begin
                    rq.pt.x = a.x ^ SAMPLE_BITS'($urandom_range(0, 15));
                    rq.pt.y = a.y ^ SAMPLE_BITS'($urandom_range(0, 15));
                    rq.pt.z = a.z ^ SAMPLE_BITS'($urandom_range(0, 15));
                end
                3: begin                          // midway, often equidistant
                    rq.pt.x = SAMPLE_BITS'((int'(a.x) + int'(b.x)) / 2);
                    rq.pt.y = SAMPLE_BITS'((int'(a.y) + int'(b.y)) / 2);
                    rq.pt.z = SAMPLE_BITS'((int'(a.z) + int'(b.z)) / 2);
                end
                4: rq.pt = a;
                5: begin
                    rq.pt.x = edge_coord();
                    rq.pt.y = edge_coord();
                    rq.pt.z = edge_coord();
                end
                default: ;
            endcase
        end else if (pick < 98) begin
            op = OP_READ;
            rq.row = biased_index();
            rq.col = biased_index();
        end else begin
            op = OP_CLEAR;
        end
    endtask

    initial begin
        logic [1:0] op;
        t_request   rq;
        int         burst;
        bit         drained_mid;
        drained_mid = 1'b0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // all centres still zero: full tie, then the largest distance
        put(OP_CLASSIFY, 0, 0, 0, 0, 0, 1'b1);
        put(OP_CLASSIFY, 1, 7, 4095, 4095, 4095, 1'b1);
        put(OP_READ, 0, 0, 0, 0, 0, 1'b0);
        put(OP_READ, 1, 0, 0, 0, 0, 1'b0);
        pause($urandom_range(1, 4));
        put(OP_LOAD, 0, 0, 4095, 4095, 4095, 1'b0);
        put(OP_LOAD, 1, 0, 4095, 0, 0, 1'b0);
        put(OP_LOAD, 2, 0, 0, 4095, 0, 1'b0);
        put(OP_LOAD, 3, 0, 4095, 0, 0, 1'b0);
        put(OP_LOAD, 4, 0, 2048, 2048, 2048, 1'b0);
        put(OP_LOAD, 6, 0, 1, 2, 3, 1'b0);
        put(OP_LOAD, 7, 7, 4095, 4095, 4095, 1'b1);
        put(OP_CLASSIFY, 5, 0, 0, 0, 0, 1'b1);
        put(OP_CLASSIFY, 2, 0, 4095, 0, 0, 1'b1);
        put(OP_CLASSIFY, 2, 0, 4095, 0, 0, 1'b0);
        pause($urandom_range(1, 4));
        put(OP_CLASSIFY, 6, 0, 2000, 2000, 2000, 1'b1);
        put(OP_CLASSIFY, 7, 7, 4095, 4095, 4095, 1'b1);
        put(OP_READ, 2, 1, 0, 0, 0, 1'b0);
        put(OP_READ, 7, 1, 0, 0, 0, 1'b0);
        put(OP_READ, 1, 6, 0, 0, 0, 1'b0);
        put(OP_READ, 7, 7, 4095, 4095, 4095, 1'b1);
        put(OP_CLEAR, 0, 0, 0, 0, 0, 1'b0);
        put(OP_CLEAR, 7, 7, 4095, 4095, 4095, 1'b1);
        put(OP_READ, 2, 1, 0, 0, 0, 1'b0);
        wait_drained();

        // drive one count up back to back, then read it back
        rx_eager = 1'b1;
        put(OP_LOAD, 2, 0, 1234, 567, 3210, 1'b0);
        repeat (REPEAT_RUN) put(OP_CLASSIFY, 4, 0, 1234, 567, 3210, 1'b1);
        put(OP_CLASSIFY, 4, 0, 1234, 567, 3210, 1'b0);
        put(OP_READ, 4, 2, 0, 0, 0, 1'b0);
        wait_drained();
        rx_eager = 1'b0;

        for (int n = 0; n < RANDOM_ITEMS; ) begin
            burst = $urandom_range(1, 24);
            repeat (burst) begin
                make_random(op, rq);
                send_request(op, rq);
                n++;
            end
            if (!drained_mid && n >= RANDOM_ITEMS / 2) begin
                wait_drained();
                drained_mid = 1'b1;
            end else begin
                pause(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.fail_count == 0)
            $display("nearest_centroid_confusion_counter_top verification clean");
        else
            $display("nearest_centroid_confusion_counter_top verification failed");
        $finish;
    end

endmodule
